[rtl/mmss_lcd_pkg.sv]
// Shared types and constants for the mm:ss character-LCD writer.
package mmss_lcd_pkg;

    // LCD bus codes
    localparam logic [7:0] CMD_SET_CURSOR = 8'h80;
    localparam logic [7:0] ASCII_ZERO     = 8'h30;

    // row 0 start columns of the two fields
    localparam logic [2:0] MIN_COL = 3'd0;
    localparam logic [2:0] SEC_COL = 3'd3;

    // weights removed by the shared subtractor
    localparam logic [7:0] WEIGHT_HUND = 8'd100;
    localparam logic [7:0] WEIGHT_TENS = 8'd10;

    // sequencer states of the top level
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    // digit conversion phase
    typedef enum logic {
        PH_HUND,
        PH_TENS
    } t_bcd_phase;

    // request into the digit converter
    typedef struct packed {
        logic       start;
        logic [7:0] value;
    } t_bcd_req;

    // status and digits out of the digit converter
    typedef struct packed {
        logic       busy;
        logic       done;
        logic [1:0] hund;
        logic [3:0] tens;
        logic [3:0] ones;
    } t_bcd_rsp;

endpackage

[rtl/mmss_lcd_bcd_unit.sv]
// Byte to decimal digits by repeated compare-and-subtract on one shared subtractor.
module mmss_lcd_bcd_unit
    import mmss_lcd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_bcd_req i_req,
    output t_bcd_rsp o_rsp
);

    logic       r_busy, n_busy;
    logic       r_done, n_done;
    t_bcd_phase r_phase, n_phase;
    logic [7:0] r_rem, n_rem;
    logic [1:0] r_hund, n_hund;
    logic [3:0] r_tens, n_tens;

    logic [7:0] weight;
    logic [8:0] diff;
    logic       take;

    // shared subtractor: borrow out doubles as the compare
    assign weight = (r_phase == PH_HUND) ? WEIGHT_HUND : WEIGHT_TENS;
    assign diff   = {1'b0, r_rem} - {1'b0, weight};
    assign take   = !diff[8];

    // one subtract step per cycle
    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_phase = r_phase;
        n_rem   = r_rem;
        n_hund  = r_hund;
        n_tens  = r_tens;
        if (i_req.start) begin
            n_busy  = 1'b1;
            n_phase = PH_HUND;
            n_rem   = i_req.value;
            n_hund  = 2'd0;
            n_tens  = 4'd0;
        end else if (r_busy) begin
            if (take) begin
                n_rem = diff[7:0];
                if (r_phase == PH_HUND) begin
                    n_hund = r_hund + 2'd1;
                end else begin
                    n_tens = r_tens + 4'd1;
                end
            end else if (r_phase == PH_HUND) begin
                n_phase = PH_TENS;
            end else begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= PH_HUND;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_phase <= n_phase;
        end
    end

    // working value and digit counts
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_hund <= n_hund;
        r_tens <= n_tens;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.hund = r_hund;
    assign o_rsp.tens = r_tens;
    assign o_rsp.ones = r_rem[3:0];

endmodule

[rtl/mmss_char_lcd_writer_unit.sv]
// Top level: mm:ss to character-LCD row 0 write sequence.
// One item at a time. Each of the two values is converted to digits by a shared
// subtractor, then its 3 or 4 writes leave at one word per cycle while the output
// side is ready; a new item is accepted only once the last write has been loaded.
// Synchronous active-low reset returns the sequencer to idle and empties the output.
module mmss_char_lcd_writer_unit
    import mmss_lcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] minutes, [15:8] seconds
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] bus_byte
    output logic        o_m_tuser,   // [0] is_data
    output logic        o_m_tlast    // last_write
);

    t_state     r_state, n_state;
    logic       r_is_sec, n_is_sec;
    logic [1:0] r_step, n_step;
    logic [7:0] r_sec;

    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic       r_out_user;
    logic       r_out_last;

    t_bcd_req   bcd_req;
    t_bcd_rsp   bcd_rsp;

    logic       s_accept;
    logic       load;
    logic [2:0] col;
    logic       below_ten;
    logic [1:0] last_step;
    logic       w_is_data;
    logic [7:0] w_byte;

    function automatic logic [7:0] to_ascii(input logic [3:0] d);
        to_ascii = ASCII_ZERO | {4'd0, d};
    endfunction

    mmss_lcd_bcd_unit u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (bcd_req),
        .o_rsp   (bcd_rsp)
    );

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign load       = (r_state == ST_EMIT) && (!r_out_valid || i_m_tready);

    // write selection for the current step of the current value
    assign col       = r_is_sec ? SEC_COL : MIN_COL;
    assign below_ten = (bcd_rsp.hund == 2'd0) && (bcd_rsp.tens == 4'd0);
    assign last_step = (below_ten || (bcd_rsp.hund != 2'd0)) ? 2'd3 : 2'd2;

    always_comb begin
        w_is_data = 1'b1;
        w_byte    = to_ascii(bcd_rsp.ones);
        case (r_step)
            2'd0: begin
                w_is_data = 1'b0;
                w_byte    = CMD_SET_CURSOR | {5'd0, col};
            end
            2'd1: begin
                if (below_ten) begin
                    w_byte = ASCII_ZERO;
                end else if (bcd_rsp.hund != 2'd0) begin
                    w_byte = to_ascii({2'd0, bcd_rsp.hund});
                end else begin
                    w_byte = to_ascii(bcd_rsp.tens);
                end
            end
            2'd2: begin
                if (below_ten) begin
                    w_is_data = 1'b0;
                    w_byte    = CMD_SET_CURSOR | {5'd0, col + 3'd1};
                end else if (bcd_rsp.hund != 2'd0) begin
                    w_byte = to_ascii(bcd_rsp.tens);
                end else begin
                    w_byte = to_ascii(bcd_rsp.ones);
                end
            end
            default: begin
                w_byte = to_ascii(bcd_rsp.ones);
            end
        endcase
    end

    // sequencer: convert minutes, emit, convert seconds, emit
    always_comb begin
        n_state       = r_state;
        n_is_sec      = r_is_sec;
        n_step        = r_step;
        bcd_req.start = 1'b0;
        bcd_req.value = r_sec;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    bcd_req.start = 1'b1;
                    bcd_req.value = i_s_tdata[7:0];
                    n_is_sec      = 1'b0;
                    n_state       = ST_CONV;
                end
            end
            ST_CONV: begin
                if (bcd_rsp.done) begin
                    n_step  = 2'd0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (load) begin
                    if (r_step == last_step) begin
                        if (r_is_sec) begin
                            n_state = ST_IDLE;
                        end else begin
                            bcd_req.start = 1'b1;
                            n_is_sec      = 1'b1;
                            n_state       = ST_CONV;
                        end
                    end else begin
                        n_step = r_step + 2'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_is_sec <= 1'b0;
            r_step   <= 2'd0;
        end else begin
            r_state  <= n_state;
            r_is_sec <= n_is_sec;
            r_step   <= n_step;
        end
    end

    // seconds held until its conversion starts
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_sec <= i_s_tdata[15:8];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data <= w_byte;
            r_out_user <= w_is_data;
            r_out_last <= r_is_sec && (r_step == last_step);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;
    assign o_m_tlast  = r_out_last;

    // converter only finishes while the sequencer waits for it
    a_done_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bcd_rsp.done |-> (r_state == ST_CONV))
        else $error("digit converter finished outside conversion");

    // converter is quiet whenever the block is idle or emitting
    a_busy_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bcd_rsp.busy |-> (r_state == ST_CONV))
        else $error("digit converter busy outside conversion");

    // digits are decimal when handed over
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bcd_rsp.done |-> (bcd_rsp.tens <= 4'd9) && (bcd_rsp.ones <= 4'd9)
                         && (bcd_rsp.hund <= 2'd2))
        else $error("digit out of decimal range");

    // an accepted item starts its minutes conversion
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == ST_CONV) && !r_is_sec && bcd_rsp.busy)
        else $error("accepted item did not start conversion");

    // the marked last word is the one that returns the block to idle
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_is_sec && (r_step == last_step)) |=> (r_state == ST_IDLE))
        else $error("last write did not end the sequence");

endmodule
